// ===== hw/rtl/spc_pkg.sv =====
// shared types and constants for the streaming pearson correlation core
package spc_pkg;

    localparam int MAX_PAIRS_DEF = 65535;

    typedef struct packed {
        logic signed [31:0] x_sample;
        logic signed [31:0] y_sample;
        logic               pair_valid;
        logic               last_pair;
    } spc_in_t;

    typedef struct packed {
        logic signed [31:0] correlation;
        logic [15:0]        pairs_used;
        logic               degenerate;
    } spc_out_t;

    typedef enum logic [1:0] {
        OP_SKIP,
        OP_PAIR,
        OP_LAST,
        OP_PAIR_LAST
    } spc_op_t;

    // classified request handed from front to back, samples already in Q16.32
    typedef struct packed {
        spc_op_t            op;
        logic signed [47:0] xs;
        logic signed [47:0] ys;
    } spc_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MEAN,
        S_DELTA,
        S_MUL,
        S_ACC,
        S_FIN,
        S_FMUL,
        S_SQRT,
        S_QSET,
        S_QDIV,
        S_EMIT
    } spc_state_t;

endpackage

// ===== hw/rtl/spc_front.sv =====
// input side: two-entry request queue that classifies each pair on entry
module spc_front
    import spc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  spc_in_t   sample,
    output logic      item_valid,
    input  logic      item_take,
    output spc_item_t item
);

    spc_item_t  mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;
    spc_item_t  cls;

    always_comb
    begin
        case ({sample.pair_valid, sample.last_pair})
            2'b00:   cls.op = OP_SKIP;
            2'b01:   cls.op = OP_LAST;
            2'b10:   cls.op = OP_PAIR;
            default: cls.op = OP_PAIR_LAST;
        endcase
        cls.xs = {sample.x_sample, 16'b0};
        cls.ys = {sample.y_sample, 16'b0};
    end

    assign full       = (fill_reg == 2'd2);
    assign item_valid = (fill_reg != 2'd0);
    assign item       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== hw/rtl/spc_back.sv =====
// execution side: welford update, co-moment products, root and final divide
module spc_back
    import spc_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_take,
    input  spc_item_t item,
    output logic      res_valid,
    input  logic      res_take,
    output spc_out_t  res
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam logic [6:0] DIV_LAST  = 7'd24;
    localparam logic [6:0] SQRT_LAST = 7'd63;
    localparam logic [6:0] QDIV_LAST = 7'd29;

    spc_state_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [47:0] mx_reg, mx_next, my_reg, my_next;
    logic signed [63:0] cxx_reg, cxx_next, cyy_reg, cyy_next, cxy_reg, cxy_next;
    logic               last_reg, last_next;

    logic signed [47:0] xs_reg, xs_next, ys_reg, ys_next;
    logic signed [48:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [48:0]        dxm_reg, dxm_next, dym_reg, dym_next;
    logic [48:0]        dxnm_reg, dxnm_next, dynm_reg, dynm_next;
    logic               sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic               sdxn_reg, sdxn_next, sdyn_reg, sdyn_next;
    logic [49:0]        divx_reg, divx_next, divy_reg, divy_next;
    logic [CNT_W-1:0]   remx_reg, remx_next, remy_reg, remy_next;
    logic [6:0]         step_reg, step_next;
    logic [1:0]         psel_reg, psel_next;
    logic [1:0]         midx_reg, midx_next;
    logic [127:0]       acc_reg, acc_next;
    logic [127:0]       rad_reg, rad_next;
    logic [66:0]        srem_reg, srem_next;
    logic [63:0]        root_reg, root_next;
    logic [63:0]        qrem_reg, qrem_next;
    logic [30:0]        q_reg, q_next;
    logic               deg_reg, deg_next;

    // helpers
    logic [63:0]        op_a, op_b;
    logic               op_neg;
    logic [31:0]        ch_a, ch_b;
    logic [63:0]        pp;
    logic [6:0]         pp_sh;
    logic [127:0]       acc_add;
    logic signed [63:0] term;
    logic [31:0]        cnt_wide;

    function automatic logic [48:0] mag49(input logic signed [48:0] v);
        mag49 = v[48] ? 49'(-v) : 49'(v);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            sat_add = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else
            sat_add = s[63:0];
    endfunction

    // one restoring divide step; rem stays below the divisor
    function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
                                                input logic in_bit,
                                                input logic [CNT_W-1:0] d);
        logic [CNT_W:0] t;
        t = {rem, in_bit};
        if (t >= {1'b0, d})
            div_step = {1'b1, CNT_W'(t - {1'b0, d})};
        else
            div_step = {1'b0, t[CNT_W-1:0]};
    endfunction

    always_comb
    begin
        case (psel_reg)
            2'd0:    begin op_a = 64'(dxm_reg); op_b = 64'(dxnm_reg); op_neg = sdx_reg ^ sdxn_reg; end
            2'd1:    begin op_a = 64'(dym_reg); op_b = 64'(dynm_reg); op_neg = sdy_reg ^ sdyn_reg; end
            default: begin op_a = 64'(dxm_reg); op_b = 64'(dynm_reg); op_neg = sdx_reg ^ sdyn_reg; end
        endcase
        if (state_reg == S_FMUL)
        begin
            op_a   = cxx_reg;
            op_b   = cyy_reg;
            op_neg = 1'b0;
        end
        ch_a    = midx_reg[0] ? op_a[63:32] : op_a[31:0];
        ch_b    = midx_reg[1] ? op_b[63:32] : op_b[31:0];
        pp      = 64'(ch_a) * 64'(ch_b);
        pp_sh   = {2'(midx_reg[0]) + 2'(midx_reg[1]), 5'b0};
        acc_add = acc_reg + (128'(pp) << pp_sh);

        // product >> 32 with saturation, sign applied to the magnitude
        if (|acc_reg[127:95])
            term = op_neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else
            term = op_neg ? -$signed({1'b0, acc_reg[94:32]}) : $signed({1'b0, acc_reg[94:32]});
    end

    assign cnt_wide = 32'(cnt_reg);

    always_comb
    begin
        logic [CNT_W:0]     sx, sy;
        logic [49:0]        dvx, dvy;
        logic [CNT_W-1:0]   rx, ry;
        logic signed [49:0] qs;
        logic signed [49:0] msum;
        logic signed [48:0] dn;
        logic [66:0]        tmp, trial;
        logic [64:0]        t65;
        logic [63:0]        num;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        cxx_next   = cxx_reg;
        cyy_next   = cyy_reg;
        cxy_next   = cxy_reg;
        last_next  = last_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dxm_next   = dxm_reg;
        dym_next   = dym_reg;
        dxnm_next  = dxnm_reg;
        dynm_next  = dynm_reg;
        sdx_next   = sdx_reg;
        sdy_next   = sdy_reg;
        sdxn_next  = sdxn_reg;
        sdyn_next  = sdyn_reg;
        divx_next  = divx_reg;
        divy_next  = divy_reg;
        remx_next  = remx_reg;
        remy_next  = remy_reg;
        step_next  = step_reg;
        psel_next  = psel_reg;
        midx_next  = midx_reg;
        acc_next   = acc_reg;
        rad_next   = rad_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        qrem_next  = qrem_reg;
        q_next     = q_reg;
        deg_next   = deg_reg;
        item_take  = 1'b0;
        res_valid  = 1'b0;
        sx = '0; sy = '0; dvx = '0; dvy = '0; rx = '0; ry = '0;
        qs = '0; msum = '0; dn = '0; tmp = '0; trial = '0; t65 = '0; num = '0;

        res.correlation = cxy_reg[63] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        res.pairs_used  = cnt_wide[15:0];
        res.degenerate  = deg_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_take = 1'b1;
                    last_next = (item.op == OP_LAST) || (item.op == OP_PAIR_LAST);
                    if (((item.op == OP_PAIR) || (item.op == OP_PAIR_LAST))
                        && (cnt_reg < CNT_W'(MAX_PAIRS)))
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        xs_next    = item.xs;
                        ys_next    = item.ys;
                        dx_next    = {item.xs[47], item.xs} - {mx_reg[47], mx_reg};
                        dy_next    = {item.ys[47], item.ys} - {my_reg[47], my_reg};
                        state_next = S_PREP;
                    end
                    else if ((item.op == OP_LAST) || (item.op == OP_PAIR_LAST))
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_PREP:
            begin
                dxm_next   = mag49(dx_reg);
                dym_next   = mag49(dy_reg);
                sdx_next   = dx_reg[48];
                sdy_next   = dy_reg[48];
                divx_next  = {1'b0, mag49(dx_reg)};
                divy_next  = {1'b0, mag49(dy_reg)};
                remx_next  = '0;
                remy_next  = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // two quotient bits per cycle for both lanes
                dvx = divx_reg;
                dvy = divy_reg;
                rx  = remx_reg;
                ry  = remy_reg;
                for (int i = 0; i < 2; i++)
                begin
                    sx  = div_step(rx, dvx[49], cnt_reg);
                    sy  = div_step(ry, dvy[49], cnt_reg);
                    rx  = sx[CNT_W-1:0];
                    ry  = sy[CNT_W-1:0];
                    dvx = {dvx[48:0], sx[CNT_W]};
                    dvy = {dvy[48:0], sy[CNT_W]};
                end
                divx_next = dvx;
                divy_next = dvy;
                remx_next = rx;
                remy_next = ry;
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                    state_next = S_MEAN;
            end
            S_MEAN:
            begin
                qs      = sdx_reg ? -$signed({1'b0, divx_reg[48:0]}) : $signed({1'b0, divx_reg[48:0]});
                msum    = {{2{mx_reg[47]}}, mx_reg} + qs;
                mx_next = msum[47:0];
                qs      = sdy_reg ? -$signed({1'b0, divy_reg[48:0]}) : $signed({1'b0, divy_reg[48:0]});
                msum    = {{2{my_reg[47]}}, my_reg} + qs;
                my_next = msum[47:0];
                state_next = S_DELTA;
            end
            S_DELTA:
            begin
                dn         = {xs_reg[47], xs_reg} - {mx_reg[47], mx_reg};
                dxnm_next  = mag49(dn);
                sdxn_next  = dn[48];
                dn         = {ys_reg[47], ys_reg} - {my_reg[47], my_reg};
                dynm_next  = mag49(dn);
                sdyn_next  = dn[48];
                psel_next  = 2'd0;
                midx_next  = 2'd0;
                acc_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_next  = acc_add;
                midx_next = midx_reg + 1'b1;
                if (midx_reg == 2'd3)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                case (psel_reg)
                    2'd0:    cxx_next = sat_add(cxx_reg, term);
                    2'd1:    cyy_next = sat_add(cyy_reg, term);
                    default: cxy_next = sat_add(cxy_reg, term);
                endcase
                acc_next  = '0;
                midx_next = 2'd0;
                psel_next = psel_reg + 1'b1;
                if (psel_reg == 2'd2)
                    state_next = last_reg ? S_FIN : S_IDLE;
                else
                    state_next = S_MUL;
            end
            S_FIN:
            begin
                if ((cnt_reg == '0) || (cxx_reg <= 0) || (cyy_reg <= 0))
                begin
                    deg_next   = 1'b1;
                    q_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    deg_next   = 1'b0;
                    acc_next   = '0;
                    midx_next  = 2'd0;
                    state_next = S_FMUL;
                end
            end
            S_FMUL:
            begin
                acc_next  = acc_add;
                midx_next = midx_reg + 1'b1;
                if (midx_reg == 2'd3)
                begin
                    rad_next   = acc_add;
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // one root bit per cycle
                tmp   = {srem_reg[64:0], rad_reg[127:126]};
                trial = {1'b0, root_reg, 2'b01};
                if (tmp >= trial)
                begin
                    srem_next = tmp - trial;
                    root_next = {root_reg[62:0], 1'b1};
                end
                else
                begin
                    srem_next = tmp;
                    root_next = {root_reg[62:0], 1'b0};
                end
                rad_next  = {rad_reg[125:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == SQRT_LAST)
                    state_next = S_QSET;
            end
            S_QSET:
            begin
                num = cxy_reg[63] ? 64'(-cxy_reg) : 64'(cxy_reg);
                if ((root_reg == '0) || (num >= root_reg))
                begin
                    q_next     = 31'(1) << 30;
                    state_next = S_EMIT;
                end
                else
                begin
                    qrem_next  = num;
                    q_next     = '0;
                    step_next  = '0;
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                t65 = {qrem_reg, 1'b0};
                if (t65 >= {1'b0, root_reg})
                begin
                    qrem_next = 64'(t65 - {1'b0, root_reg});
                    q_next    = {q_reg[29:0], 1'b1};
                end
                else
                begin
                    qrem_next = t65[63:0];
                    q_next    = {q_reg[29:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == QDIV_LAST)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    cnt_next   = '0;
                    mx_next    = '0;
                    my_next    = '0;
                    cxx_next   = '0;
                    cyy_next   = '0;
                    cxy_next   = '0;
                    last_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            mx_reg    <= '0;
            my_reg    <= '0;
            cxx_reg   <= '0;
            cyy_reg   <= '0;
            cxy_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mx_reg    <= mx_next;
            my_reg    <= my_next;
            cxx_reg   <= cxx_next;
            cyy_reg   <= cyy_next;
            cxy_reg   <= cxy_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg   <= xs_next;
        ys_reg   <= ys_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dxm_reg  <= dxm_next;
        dym_reg  <= dym_next;
        dxnm_reg <= dxnm_next;
        dynm_reg <= dynm_next;
        sdx_reg  <= sdx_next;
        sdy_reg  <= sdy_next;
        sdxn_reg <= sdxn_next;
        sdyn_reg <= sdyn_next;
        divx_reg <= divx_next;
        divy_reg <= divy_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        step_reg <= step_next;
        psel_reg <= psel_next;
        midx_reg <= midx_next;
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        qrem_reg <= qrem_next;
        q_reg    <= q_next;
        deg_reg  <= deg_next;
    end

endmodule

// ===== hw/rtl/streaming_pearson_correlation_core.sv =====
// top level of the streaming pearson correlation core
// Requests enter a two-entry queue and are worked one at a time. A valid pair
// runs the two running-mean divisions by the count (two quotient bits per
// cycle, x and y side by side), then the three co-moment products on one
// 32x32 multiplier (four partial products each). A skipped pair only leaves
// the queue. The last pair adds the bit-serial square root of Sxx*Syy and a
// bit-serial divide for the Q1.30 ratio; a degenerate list skips both. One
// finished result waits in an output register, so the next list is still
// worked while it is not popped; a second result stalls until it is.
module streaming_pearson_correlation_core
    import spc_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  spc_in_t  sample,
    output logic     empty,
    input  logic     pop,
    output spc_out_t result
);

    logic      item_valid, item_take;
    spc_item_t item;
    logic      res_valid, res_take;
    spc_out_t  res;
    logic      out_valid_reg, out_valid_next;
    spc_out_t  out_reg;

    spc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    spc_back #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    assign res_take = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
            out_valid_next = 1'b1;
        else if (pop && out_valid_reg)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
            out_reg <= res;
    end

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.degenerate) |-> (result.correlation == 32'sd0))
        else $error("degenerate result with nonzero coefficient");

    a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.correlation <= 32'sd1073741824)
                    && (result.correlation >= -32'sd1073741824)))
        else $error("coefficient outside unit range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(result.pairs_used) <= 32'(MAX_PAIRS)))
        else $error("pair count above its limit");

endmodule

// ===== tb/sv/streaming_pearson_correlation_core_tb.sv =====
// testbench for the streaming pearson correlation core
module streaming_pearson_correlation_core_tb;
    import spc_pkg::*;

    localparam int MAX_CYCLES = 4000000;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    spc_in_t  sample;
    logic     empty;
    logic     pop;
    spc_out_t result;

    streaming_pearson_correlation_core u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .sample (sample),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    spc_in_t  pending_samples[$];
    spc_out_t expected_results[$];
    int       error_count;
    int       cycle_count;
    bit       stimulus_done;

    // running statistics of the list in progress
    int unsigned     stat_count;
    logic signed [63:0] stat_mean_x;
    logic signed [63:0] stat_mean_y;
    logic signed [63:0] stat_sxx;
    logic signed [63:0] stat_syy;
    logic signed [63:0] stat_sxy;

    function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                          logic signed [63:0] b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic [63:0]  m;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = {64'd0, ma} * {64'd0, mb};
        if (p[127:96] != 0)
            m = 64'h8000_0000_0000_0000;
        else
            m = p[95:32];
        if (neg)
            return m[63] ? 64'sh8000_0000_0000_0000 : -$signed(m);
        return m[63] ? 64'sh7fff_ffff_ffff_ffff : $signed(m);
    endfunction

    function automatic logic signed [63:0] add_saturated(logic signed [63:0] a,
                                                         logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7fff_ffff_ffff_ffff)
            return 64'sh7fff_ffff_ffff_ffff;
        if (s < -65'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic logic [63:0] floor_root(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] sq;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= v)
                r = cand;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] pearson_ratio();
        logic [127:0] prod;
        logic [63:0]  r;
        logic [63:0]  num;
        logic [63:0]  rem;
        logic [31:0]  q;
        prod = {64'd0, stat_sxx} * {64'd0, stat_syy};
        r = floor_root(prod);
        num = stat_sxy < 0 ? -stat_sxy : stat_sxy;
        q = 0;
        if (r == 0 || num >= r)
            q = 32'd1 << 30;
        else
        begin
            rem = num;
            for (int i = 0; i < 30; i++)
            begin
                q = q << 1;
                if (rem >= r - rem)
                begin
                    rem = rem - (r - rem);
                    q[0] = 1'b1;
                end
                else
                    rem = rem << 1;
            end
        end
        return stat_sxy < 0 ? -$signed(q) : $signed(q);
    endfunction

    task automatic clear_statistics();
        stat_count = 0;
        stat_mean_x = 0;
        stat_mean_y = 0;
        stat_sxx = 0;
        stat_syy = 0;
        stat_sxy = 0;
    endtask

    task automatic predict_correlation(spc_in_t s);
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] dxn;
        logic signed [63:0] dyn;
        spc_out_t           res;
        if (s.pair_valid && stat_count < MAX_PAIRS_DEF)
        begin
            xs = 64'(s.x_sample) <<< 16;
            ys = 64'(s.y_sample) <<< 16;
            stat_count++;
            dx = xs - stat_mean_x;
            dy = ys - stat_mean_y;
            stat_mean_x += dx / $signed({32'd0, stat_count});
            stat_mean_y += dy / $signed({32'd0, stat_count});
            dxn = xs - stat_mean_x;
            dyn = ys - stat_mean_y;
            stat_sxx = add_saturated(stat_sxx, scaled_product(dx, dxn));
            stat_syy = add_saturated(stat_syy, scaled_product(dy, dyn));
            stat_sxy = add_saturated(stat_sxy, scaled_product(dx, dyn));
        end
        if (s.last_pair)
        begin
            if (stat_count == 0 || stat_sxx <= 0 || stat_syy <= 0)
            begin
                res.correlation = 0;
                res.degenerate = 1'b1;
            end
            else
            begin
                res.correlation = pearson_ratio();
                res.degenerate = 1'b0;
            end
            res.pairs_used = stat_count[15:0];
            expected_results.push_back(res);
            clear_statistics();
        end
    endtask

    function automatic spc_in_t make_pair(logic [31:0] x, logic [31:0] y, bit v, bit l);
        spc_in_t s;
        s.x_sample = x;
        s.y_sample = y;
        s.pair_valid = v;
        s.last_pair = l;
        return s;
    endfunction

    function automatic logic [31:0] random_value(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // stimulus
    initial
    begin
        int list_len;
        int mode;
        int corr_mode;
        int made;
        logic [31:0] xv;
        logic [31:0] yv;
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        clear_statistics();
        // directed lists
        pending_samples.push_back(make_pair(0, 0, 0, 1));                   // empty list
        pending_samples.push_back(make_pair(32'h0001_0000, 32'h0002_0000, 1, 1)); // one pair
        pending_samples.push_back(make_pair(32'h0001_0000, 32'h0001_0000, 1, 0));
        pending_samples.push_back(make_pair(32'h0001_0000, 32'h0005_0000, 1, 0));
        pending_samples.push_back(make_pair(32'h0001_0000, 32'h0003_0000, 1, 1)); // zero variance x
        pending_samples.push_back(make_pair(32'h0001_0000, 32'h0002_0000, 1, 0));
        pending_samples.push_back(make_pair(32'hdead_beef, 32'h1234_5678, 0, 0)); // skipped
        pending_samples.push_back(make_pair(32'h0002_0000, 32'h0004_0000, 1, 0));
        pending_samples.push_back(make_pair(32'h0003_0000, 32'h0006_0000, 1, 1)); // perfect +1
        pending_samples.push_back(make_pair(32'h0001_0000, 32'h0003_0000, 1, 0));
        pending_samples.push_back(make_pair(32'h0002_0000, 32'h0002_0000, 1, 0));
        pending_samples.push_back(make_pair(32'h0003_0000, 32'h0001_0000, 1, 0));
        pending_samples.push_back(make_pair(32'h0000_0000, 32'h0000_0000, 0, 1)); // -1, invalid last
        pending_samples.push_back(make_pair(32'h7fff_ffff, 32'h8000_0000, 1, 0));
        pending_samples.push_back(make_pair(32'h8000_0000, 32'h7fff_ffff, 1, 0));
        pending_samples.push_back(make_pair(32'h7fff_ffff, 32'h7fff_ffff, 1, 0));
        pending_samples.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 1, 1)); // extremes
        pending_samples.push_back(make_pair(32'hffff_ffff, 32'h0000_0001, 1, 0));
        pending_samples.push_back(make_pair(32'h0000_0001, 32'hffff_ffff, 1, 1)); // tiny values
        made = pending_samples.size();
        while (made < 1650)
        begin
            list_len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(2, 40);
            mode = $urandom_range(0, 3);
            corr_mode = $urandom_range(0, 3);
            for (int i = 0; i < list_len; i++)
            begin
                xv = random_value(mode);
                case (corr_mode)
                    0: yv = xv + $urandom_range(0, 255);
                    1: yv = -xv;
                    default: yv = random_value(mode);
                endcase
                pending_samples.push_back(make_pair(xv, yv, $urandom_range(0, 9) != 0,
                                                    i == list_len - 1));
            end
            made += list_len;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_samples.size() == 0);
        stimulus_done = 1'b1;
    end

    // driver: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            sample <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_correlation(sample);
            end
            if (!(push && full))
            begin
                if (push && !full && burst_left > 0 && pending_samples.size() != 0)
                begin
                    sample <= pending_samples.pop_front();
                    burst_left <= burst_left - 1;
                end
                else if (gap_left > 0)
                begin
                    push <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_samples.size() != 0)
                begin
                    push <= 1'b1;
                    sample <= pending_samples.pop_front();
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor and stalling receiver
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result correlation=%0d", result.correlation);
                    error_count++;
                end
                else
                begin
                    spc_out_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (result.correlation !== exp_r.correlation)
                    begin
                        $error("correlation expected %0d actual %0d",
                               exp_r.correlation, result.correlation);
                        error_count++;
                    end
                    if (result.pairs_used !== exp_r.pairs_used)
                    begin
                        $error("pairs_used expected %0d actual %0d",
                               exp_r.pairs_used, result.pairs_used);
                        error_count++;
                    end
                    if (result.degenerate !== exp_r.degenerate)
                    begin
                        $error("degenerate expected %0d actual %0d",
                               exp_r.degenerate, result.degenerate);
                        error_count++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 512;
            // long stall window, then random pops, then free flow
            if (stall_phase < 150)
                pop <= 1'b0;
            else if (stall_phase < 350)
                pop <= $urandom_range(0, 2) == 0;
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        fork
            begin
                wait (stimulus_done);
                @(posedge clk);
                while (push || expected_results.size() != 0)
                    @(posedge clk);
                repeat (300) @(posedge clk);
                if (error_count == 0 && expected_results.size() == 0)
                    $display("streaming_pearson_correlation_core_tb: PASS");
                else
                    $display("streaming_pearson_correlation_core_tb: FAIL");
                $finish;
            end
            begin
                while (cycle_count < MAX_CYCLES)
                begin
                    @(posedge clk);
                    cycle_count++;
                end
                $display("streaming_pearson_correlation_core_tb: FAIL");
                $finish;
            end
        join
    end

endmodule

// ===== files.f =====
hw/rtl/spc_pkg.sv
hw/rtl/spc_front.sv
hw/rtl/spc_back.sv
hw/rtl/streaming_pearson_correlation_core.sv
tb/sv/streaming_pearson_correlation_core_tb.sv
